>>> sv/weighted_discrete_sampler_top_defines.svh
// Assertion macros for the weighted discrete sampler.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef WEIGHTED_DISCRETE_SAMPLER_TOP_DEFINES_SVH
`define WEIGHTED_DISCRETE_SAMPLER_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge outside reset
`define WDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wds: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define WDS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wds: next-cycle check failed");

`else

`define WDS_ASSERT_IMP(label, ante, cons)

`define WDS_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> sv/wds_pkg.sv
// Shared types and constants for the weighted discrete sampler.
// No dependencies; used by wds_ctrl, wds_datapath and the top level.
package wds_pkg;

    // Fixed field widths
    localparam int MODE_W       = 2;
    localparam int WEIGHT_BITS  = 16;
    localparam int UNIFORM_BITS = 32;
    localparam int PREFIX_W     = 24;
    localparam int INDEX_OUT_W  = 8;
    localparam int PROD_W       = PREFIX_W + UNIFORM_BITS;

    // Default table depth
    localparam int DEFAULT_MAX_ENTRIES = 256;

    // Saturation value of the running sum
    localparam logic [PREFIX_W-1:0] PREFIX_MAX = {PREFIX_W{1'b1}};

    // Input word operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_DRAW   = 2'd2
    } wds_mode_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_CMP,
        ST_POST
    } wds_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic capture_draw;
        logic start_search;
        logic set_error;
        logic issue_read;
        logic update_bounds;
        logic set_found;
        logic push_out;
    } wds_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic draw_bad;
        logic search_open;
        logic out_free;
    } wds_status_t;

endpackage

>>> sv/wds_ctrl.sv
// Controller state machine for the weighted discrete sampler.
// Depends on wds_pkg for state, mode, command and status types.
module wds_ctrl
    import wds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [MODE_W-1:0]   mode,
    input  wds_status_t         status,
    output logic                in_ready,
    output wds_cmd_t            cmd
);

    wds_state_t state_reg;
    wds_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (wds_mode_t'(mode))
                        MODE_APPEND: state_next = ST_POST;
                        MODE_DRAW:   state_next = ST_CHECK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK:
            begin
                state_next = status.draw_bad ? ST_POST : ST_READ;
            end
            ST_READ:
            begin
                state_next = status.search_open ? ST_CMP : ST_POST;
            end
            ST_CMP:
            begin
                state_next = ST_READ;
            end
            ST_POST:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (wds_mode_t'(mode))
                        MODE_CLEAR:  cmd.clear        = 1'b1;
                        MODE_APPEND: cmd.append       = 1'b1;
                        MODE_DRAW:   cmd.capture_draw = 1'b1;
                        default:     cmd              = '0;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (status.draw_bad)
                begin
                    cmd.set_error = 1'b1;
                end
                else
                begin
                    cmd.start_search = 1'b1;
                end
            end
            ST_READ:
            begin
                if (status.search_open)
                begin
                    cmd.issue_read = 1'b1;
                end
                else
                begin
                    cmd.set_found = 1'b1;
                end
            end
            ST_CMP:
            begin
                cmd.update_bounds = 1'b1;
            end
            ST_POST:
            begin
                cmd.push_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/wds_datapath.sv
// Datapath for the weighted discrete sampler: prefix memory, running total,
// product register, search bounds and output register. Depends on wds_pkg.
`include "weighted_discrete_sampler_top_defines.svh"

module wds_datapath
    import wds_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wds_cmd_t                cmd,
    input  logic [WEIGHT_BITS-1:0]  weight_value,
    input  logic [UNIFORM_BITS-1:0] uniform_value,
    input  logic                    out_ready,
    output wds_status_t             status,
    output logic                    out_valid,
    output logic [INDEX_OUT_W-1:0]  sample_index,
    output logic                    error_flag
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = PREFIX_W + 1;

    // Prefix sum store, undefined until written
    logic [PREFIX_W-1:0] prefix_mem [MAX_ENTRIES];

    logic [CNT_W-1:0]        count_reg;
    logic [PREFIX_W-1:0]     total_reg;
    logic [UNIFORM_BITS-1:0] u_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [IDX_W-1:0]        low_reg;
    logic [IDX_W-1:0]        high_reg;
    logic [IDX_W-1:0]        mid_reg;
    logic [PREFIX_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]        res_idx_reg;
    logic                    res_err_reg;
    logic                    out_valid_reg;
    logic [INDEX_OUT_W-1:0]  sample_index_reg;
    logic                    error_flag_reg;

    logic                    full;
    logic [PREFIX_W-1:0]     prev_sum;
    logic [SUM_W-1:0]        sum_wide;
    logic [PREFIX_W-1:0]     sum_sat;
    logic [IDX_W-1:0]        mid;
    logic                    covers;
    logic                    out_free;

    // Decode table fill and saturating running sum
    assign full     = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign prev_sum = (count_reg == '0) ? '0 : total_reg;
    assign sum_wide = {1'b0, prev_sum} + SUM_W'(weight_value);
    assign sum_sat  = sum_wide[PREFIX_W] ? PREFIX_MAX : sum_wide[PREFIX_W-1:0];

    // Search midpoint and coverage test u * total <= prefix * 2^UNIFORM_BITS
    assign mid    = low_reg + ((high_reg - low_reg) >> 1);
    assign covers = (prod_reg <= {rd_data_reg, {UNIFORM_BITS{1'b0}}});

    assign out_free = !out_valid_reg || out_ready;

    assign status.draw_bad    = (count_reg < CNT_W'(2)) || (total_reg == '0);
    assign status.search_open = (low_reg < high_reg);
    assign status.out_free    = out_free;

    // Write appended prefix sums
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            prefix_mem[count_reg[IDX_W-1:0]] <= sum_sat;
        end
    end

    // Registered read at the search midpoint
    always_ff @(posedge clk)
    begin
        if (cmd.issue_read)
        begin
            rd_data_reg <= prefix_mem[mid];
            mid_reg     <= mid;
        end
    end

    // Track entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.append && !full)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Hold total, draw operand and product
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            total_reg <= sum_sat;
        end
        if (cmd.capture_draw)
        begin
            u_reg <= uniform_value;
        end
        if (cmd.start_search)
        begin
            prod_reg <= u_reg * total_reg;
        end
    end

    // Advance search bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (cmd.start_search)
        begin
            low_reg  <= '0;
            high_reg <= IDX_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.update_bounds)
        begin
            if (covers)
            begin
                high_reg <= mid_reg;
            end
            else
            begin
                low_reg <= mid_reg + IDX_W'(1);
            end
        end
    end

    // Hold pending result
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            res_idx_reg <= '0;
            res_err_reg <= full;
        end
        else if (cmd.set_error)
        begin
            res_idx_reg <= '0;
            res_err_reg <= 1'b1;
        end
        else if (cmd.set_found)
        begin
            res_idx_reg <= low_reg;
            res_err_reg <= 1'b0;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            sample_index_reg <= INDEX_OUT_W'(res_idx_reg);
            error_flag_reg   <= res_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_index = sample_index_reg;
    assign error_flag   = error_flag_reg;

    // Checks
    `WDS_ASSERT_NXT(a_count_cap, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES))
    `WDS_ASSERT_NXT(a_bounds_order, cmd.update_bounds, low_reg <= high_reg)
    `WDS_ASSERT_NXT(a_found_clean, cmd.set_found, !res_err_reg)
    `WDS_ASSERT_IMP(a_push_free, cmd.push_out, out_free)
    `WDS_ASSERT_NXT(a_search_init, cmd.start_search, low_reg < high_reg)

endmodule

>>> sv/weighted_discrete_sampler_top.sv
// Top level of the weighted discrete sampler: controller plus datapath.
// Depends on wds_pkg, wds_ctrl and wds_datapath.
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+------------------
//  input   | mode, weight_value, uniform_value              | in_valid/in_ready
//  output  | sample_index, error_flag                       | out_valid/out_ready
//
// Clear and unused mode words finish on acceptance; append goes through write
// and post. A bad draw goes through accept, check and post. A good draw goes
// through accept, a multiply state, a read and a compare state per search step,
// a final bound check and the post; the search uses the single read port of
// the prefix memory.
// Reset clears entry count, state and output valid; no memory clearing pass.
// A waiting output word holds the next result in its post cycle, with in_ready
// low, until the waiting word is taken.
module weighted_discrete_sampler_top
    import wds_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [MODE_W-1:0]       mode,
    input  logic [WEIGHT_BITS-1:0]  weight_value,
    input  logic [UNIFORM_BITS-1:0] uniform_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [INDEX_OUT_W-1:0]  sample_index,
    output logic                    error_flag
);

    wds_cmd_t    cmd;
    wds_status_t status;

    // Sequence each word
    wds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Store prefixes and run the search
    wds_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .weight_value  (weight_value),
        .uniform_value (uniform_value),
        .out_ready     (out_ready),
        .status        (status),
        .out_valid     (out_valid),
        .sample_index  (sample_index),
        .error_flag    (error_flag)
    );

endmodule
